[src/trv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trv_pkg
// Shared types and constants for the torus vertex generator.
// ----------------------------------------------------------------------------
package trv_pkg;

  // division counts saturate here
  localparam int unsigned MAX_DIV = 1024;

  // quarter-wave sine polynomial coefficients, Q1.14
  localparam logic [14:0] SIN_A   = 15'd25736;
  localparam logic [13:0] SIN_B   = 14'd10512;
  localparam logic [10:0] SIN_C   = 11'd1160;
  localparam logic [14:0] QUARTER = 15'd16384;

  // pipeline depths
  localparam int unsigned DIV_STAGES   = 17;
  localparam int unsigned SINE_STAGES  = 5;
  localparam int unsigned SHAPE_STAGES = 2;
  localparam int unsigned NUM_STAGES   = 1 + DIV_STAGES + SINE_STAGES + SHAPE_STAGES;

  // sine lanes
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned LANE_SU = 0;
  localparam int unsigned LANE_CU = 1;
  localparam int unsigned LANE_SV = 2;
  localparam int unsigned LANE_CV = 3;

  // configuration register indexes
  typedef enum logic [7:0] {
    REG_OUTER = 8'd0,
    REG_INNER = 8'd1,
    REG_RINGS = 8'd2,
    REG_SIDES = 8'd3
  } trv_reg_t;

  // sine and cosine of both angles, Q1.14
  typedef struct packed {
    logic signed [15:0] su;
    logic signed [15:0] cu;
    logic signed [15:0] sv;
    logic signed [15:0] cv;
  } trv_trig_t;

endpackage

[src/trv_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trv_if
// Channels of the torus vertex generator: config writes, grid indices, vertices.
// ----------------------------------------------------------------------------
interface trv_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface trv_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] ring_index;
  logic [10:0] side_index;
  modport source (output valid, ring_index, side_index, input ready);
  modport sink   (input valid, ring_index, side_index, output ready);
endinterface

interface trv_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] pos_x;
  logic signed [18:0] pos_y;
  logic signed [18:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_u, tex_v, output ready);
endinterface

[src/trv_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trv_divider
// Restoring divider, one quotient bit per stage, ring and side lanes together.
// ----------------------------------------------------------------------------
module trv_divider
  import trv_pkg::*;
(
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [10:0]           ring_cnt,
  input  logic [10:0]           side_cnt,
  input  logic [10:0]           ring_rem,
  input  logic [16:0]           ring_low,
  input  logic [10:0]           side_rem,
  input  logic [16:0]           side_low,
  output logic [16:0]           ring_quo,
  output logic [16:0]           side_quo
);

  logic [10:0] rrem [DIV_STAGES+1];
  logic [16:0] rlow [DIV_STAGES+1];
  logic [16:0] rquo [DIV_STAGES+1];
  logic [10:0] srem [DIV_STAGES+1];
  logic [16:0] slow [DIV_STAGES+1];
  logic [16:0] squo [DIV_STAGES+1];

  assign rrem[0] = ring_rem;
  assign rlow[0] = ring_low;
  assign rquo[0] = '0;
  assign srem[0] = side_rem;
  assign slow[0] = side_low;
  assign squo[0] = '0;

  // one trial subtract per lane and stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [11:0] rtr, str;
    logic        rge, sge;
    assign rtr = {rrem[k], rlow[k][16]};
    assign str = {srem[k], slow[k][16]};
    assign rge = rtr >= {1'b0, ring_cnt};
    assign sge = str >= {1'b0, side_cnt};
    always_ff @(posedge clk) begin
      if (en[k]) begin
        rrem[k+1] <= rge ? 11'(rtr - {1'b0, ring_cnt}) : rtr[10:0];
        rlow[k+1] <= {rlow[k][15:0], 1'b0};
        rquo[k+1] <= {rquo[k][15:0], rge};
        srem[k+1] <= sge ? 11'(str - {1'b0, side_cnt}) : str[10:0];
        slow[k+1] <= {slow[k][15:0], 1'b0};
        squo[k+1] <= {squo[k][15:0], sge};
      end
    end
  end

  assign ring_quo = rquo[DIV_STAGES];
  assign side_quo = squo[DIV_STAGES];

endmodule

[src/trv_sine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trv_sine
// Four-lane quarter-wave polynomial sine, five register stages.
// ----------------------------------------------------------------------------
module trv_sine
  import trv_pkg::*;
(
  input  logic                   clk,
  input  logic [SINE_STAGES-1:0] en,
  input  logic [15:0]            ang_u,
  input  logic [15:0]            ang_v,
  output trv_trig_t              trig
);

  logic [15:0]        ang [NUM_LANES];
  logic signed [15:0] res [NUM_LANES];

  assign ang[LANE_SU] = ang_u;
  assign ang[LANE_CU] = 16'(ang_u + 16'(QUARTER));
  assign ang[LANE_SV] = ang_v;
  assign ang[LANE_CV] = 16'(ang_v + 16'(QUARTER));

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [14:0] x_a, x_b, x_c, x_d;
    logic        neg_a, neg_b, neg_c, neg_d;
    logic [14:0] x2_b, x2_c;
    logic [13:0] in_c;
    logic [14:0] t_d;
    logic [29:0] sq;
    logic [25:0] pc;
    logic [28:0] pi;
    logic [29:0] pt;
    logic [15:0] pr;

    assign sq = x_a * x_a;
    assign pc = SIN_C * x2_b;
    assign pi = in_c * x2_c;
    assign pt = t_d * x_d;
    assign pr = 16'((pt + 30'd8192) >> 14);

    always_ff @(posedge clk) begin
      // quadrant fold
      if (en[0]) begin
        x_a   <= ang[l][14] ? 15'(QUARTER - {1'b0, ang[l][13:0]}) : {1'b0, ang[l][13:0]};
        neg_a <= ang[l][15];
      end
      // square
      if (en[1]) begin
        x2_b  <= 15'((sq + 30'd8192) >> 14);
        x_b   <= x_a;
        neg_b <= neg_a;
      end
      // innermost term
      if (en[2]) begin
        in_c  <= 14'(SIN_B - 14'((pc + 26'd8192) >> 14));
        x2_c  <= x2_b;
        x_c   <= x_b;
        neg_c <= neg_b;
      end
      // middle term
      if (en[3]) begin
        t_d   <= 15'(SIN_A - 15'((pi + 29'd8192) >> 14));
        x_d   <= x_c;
        neg_d <= neg_c;
      end
      // final product, clamp and sign
      if (en[4]) begin
        if (pr > 16'(QUARTER)) res[l] <= neg_d ? -16'sd16384 : 16'sd16384;
        else                   res[l] <= neg_d ? -$signed(pr) : $signed(pr);
      end
    end
  end

  assign trig.su = res[LANE_SU];
  assign trig.cu = res[LANE_CU];
  assign trig.sv = res[LANE_SV];
  assign trig.cv = res[LANE_CV];

endmodule

[src/trv_shape.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trv_shape
// Torus position and normal from the trig values, two register stages.
// ----------------------------------------------------------------------------
module trv_shape
  import trv_pkg::*;
(
  input  logic                    clk,
  input  logic [SHAPE_STAGES-1:0] en,
  input  logic [15:0]             outer,
  input  logic [15:0]             inner,
  input  trv_trig_t               trig,
  output logic signed [18:0]      pos_x,
  output logic signed [18:0]      pos_y,
  output logic signed [18:0]      pos_z,
  output logic signed [15:0]      norm_x,
  output logic signed [15:0]      norm_y,
  output logic signed [15:0]      norm_z
);

  logic signed [32:0] icv, isv;
  logic signed [31:0] nxp, nzp;
  logic signed [18:0] r_f, py_f;
  logic signed [15:0] su_f, cu_f, nx_f, ny_f, nz_f;
  logic signed [34:0] rsu, rcu;
  logic signed [20:0] px, pz;

  // first stage: radius, y, normals
  assign icv = $signed({1'b0, inner}) * trig.cv;
  assign isv = $signed({1'b0, inner}) * trig.sv;
  assign nxp = trig.cv * trig.su;
  assign nzp = trig.cv * trig.cu;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_f  <= 19'($signed({3'b0, outer}) - 19'((icv + 33'sd8192) >>> 14));
      py_f <= 19'(-((isv + 33'sd8192) >>> 14));
      nx_f <= 16'((nxp + 32'sd8192) >>> 14);
      nz_f <= 16'((nzp + 32'sd8192) >>> 14);
      ny_f <= -trig.sv;
      su_f <= trig.su;
      cu_f <= trig.cu;
    end
  end

  // second stage: x and z from radius
  assign rsu = r_f * su_f;
  assign rcu = r_f * cu_f;
  assign px  = 21'(-((rsu + 35'sd8192) >>> 14));
  assign pz  = 21'(-((rcu + 35'sd8192) >>> 14));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      if (px > 21'sd131072)       pos_x <= 19'sd131072;
      else if (px < -21'sd131072) pos_x <= -19'sd131072;
      else                        pos_x <= px[18:0];
      if (pz > 21'sd131072)       pos_z <= 19'sd131072;
      else if (pz < -21'sd131072) pos_z <= -19'sd131072;
      else                        pos_z <= pz[18:0];
      pos_y  <= py_f;
      norm_x <= nx_f;
      norm_y <= ny_f;
      norm_z <= nz_f;
    end
  end

endmodule

[src/torus_vertex_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// torus_vertex_generator
// Grid index in, torus vertex with normal and texture coordinates out.
// ----------------------------------------------------------------------------
// Fully pipelined: one vertex per clock while the output is not stalled. The
// pipeline is the input seed registers, the 17-stage bit-per-stage divider
// that forms ring/rings and side/sides, five stages of polynomial sine for
// four angles and two stages of radius and position products. Stages stall
// on their own, so bubbles close up while the output is held. Configuration
// writes are always taken and must only happen while no word is in flight.
module torus_vertex_generator
  import trv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  trv_cfg_if.sink      cfg,
  trv_in_if.sink       item,
  trv_out_if.source    vertex
);

  localparam int unsigned TEX_DELAY = SINE_STAGES + SHAPE_STAGES;

  logic [15:0] outer, inner;
  logic [10:0] rings, sides;
  logic [10:0] ring_cnt, side_cnt;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES:0]   en;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      outer <= 16'd4096;
      inner <= 16'd1638;
      rings <= 11'd32;
      sides <= 11'd16;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OUTER: outer <= cfg.data;
        REG_INNER: inner <= cfg.data;
        REG_RINGS: rings <= cfg.data[10:0];
        REG_SIDES: sides <= cfg.data[10:0];
        default: ;
      endcase
    end
  end

  // effective counts
  always_comb begin
    ring_cnt = rings;
    if (rings == '0) ring_cnt = 11'd1;
    else if (rings > 11'(MAX_DIV)) ring_cnt = 11'(MAX_DIV);
    side_cnt = sides;
    if (sides == '0) side_cnt = 11'd1;
    else if (sides > 11'(MAX_DIV)) side_cnt = 11'(MAX_DIV);
  end

  // per-stage advance, a stage moves when empty or when the next one moves
  always_comb begin
    en[NUM_STAGES] = vertex.ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign item.ready   = en[0];
  assign vertex.valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= item.valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // input stage: saturate index and seed the divider
  logic [10:0] ring_sat, side_sat;
  logic [10:0] ring_rem, side_rem;
  logic [16:0] ring_low, side_low;

  assign ring_sat = (item.ring_index > ring_cnt) ? ring_cnt : item.ring_index;
  assign side_sat = (item.side_index > side_cnt) ? side_cnt : item.side_index;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ring_rem <= {1'b0, ring_sat[10:1]};
      ring_low <= {ring_sat[0], 6'b0, ring_cnt[10:1]};
      side_rem <= {1'b0, side_sat[10:1]};
      side_low <= {side_sat[0], 6'b0, side_cnt[10:1]};
    end
  end

  logic [16:0] tu, tv;

  trv_divider u_div (
    .clk      (clk),
    .en       (en[DIV_STAGES:1]),
    .ring_cnt (ring_cnt),
    .side_cnt (side_cnt),
    .ring_rem (ring_rem),
    .ring_low (ring_low),
    .side_rem (side_rem),
    .side_low (side_low),
    .ring_quo (tu),
    .side_quo (tv)
  );

  trv_trig_t trig;

  trv_sine u_sine (
    .clk   (clk),
    .en    (en[DIV_STAGES+SINE_STAGES:DIV_STAGES+1]),
    .ang_u (tu[15:0]),
    .ang_v (tv[15:0]),
    .trig  (trig)
  );

  trv_shape u_shape (
    .clk    (clk),
    .en     (en[NUM_STAGES-1:DIV_STAGES+SINE_STAGES+1]),
    .outer  (outer),
    .inner  (inner),
    .trig   (trig),
    .pos_x  (vertex.pos_x),
    .pos_y  (vertex.pos_y),
    .pos_z  (vertex.pos_z),
    .norm_x (vertex.norm_x),
    .norm_y (vertex.norm_y),
    .norm_z (vertex.norm_z)
  );

  // texture coordinates ride alongside the trig and shape stages
  logic [16:0] tu_d [TEX_DELAY];
  logic [16:0] tv_d [TEX_DELAY];

  always_ff @(posedge clk) begin
    if (en[DIV_STAGES+1]) begin
      tu_d[0] <= tu;
      tv_d[0] <= tv;
    end
    for (int i = 1; i < TEX_DELAY; i++) begin
      if (en[DIV_STAGES+1+i]) begin
        tu_d[i] <= tu_d[i-1];
        tv_d[i] <= tv_d[i-1];
      end
    end
  end

  assign vertex.tex_u = tu_d[TEX_DELAY-1];
  assign vertex.tex_v = tv_d[TEX_DELAY-1];

endmodule

[src/trv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trv_checker
// Port-level checks on the vertex output, bound to the top level.
// ----------------------------------------------------------------------------
module trv_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [16:0]        tex_u,
  input logic [16:0]        tex_v,
  input logic signed [15:0] norm_y
);

  // a held word stays valid and keeps its texture coordinates
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tex_u) && $stable(tex_v))
    else $error("vertex word changed while stalled");

  // pipeline is empty right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("vertex valid after reset");

  // texture coordinates never pass one
  a_tex: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tex_u <= 17'd65536 && tex_v <= 17'd65536)
    else $error("texture coordinate above one");

  // normal y is a unit sine
  a_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> norm_y <= 16'sd16384 && norm_y >= -16'sd16384)
    else $error("normal y out of range");

endmodule

bind torus_vertex_generator trv_checker u_trv_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (vertex.valid),
  .out_ready (vertex.ready),
  .tex_u     (vertex.tex_u),
  .tex_v     (vertex.tex_v),
  .norm_y    (vertex.norm_y)
);

[bench/tb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_if
// Testbench channels are the block's own interfaces; this file holds the
// clock-free word record used by the vertex predictor.
// ----------------------------------------------------------------------------
package tb_vertex_pkg;

  // one predicted vertex word
  typedef struct packed {
    logic signed [18:0] pos_x;
    logic signed [18:0] pos_y;
    logic signed [18:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
  } vertex_word_t;

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the torus vertex generator against a fixed-point vertex predictor,
// across several radius and division settings and with random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import trv_pkg::*;
  import tb_vertex_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  trv_cfg_if cfg ();
  trv_in_if  item ();
  trv_out_if vertex ();

  torus_vertex_generator u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg.sink),
    .item   (item.sink),
    .vertex (vertex.source)
  );

  always #2 clk = ~clk;

  // predictor copy of the registers
  longint outer_q, inner_q, rings_q, sides_q;
  vertex_word_t vertex_q[$];
  int  fails = 0;
  int  send_idle = 0;
  int  take_stall = 0;
  int  hold_cycles = 0;

  function automatic longint rnd_sh(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint quarter_wave(longint x);
    longint x2, a, t, p;
    x2 = rnd_sh(x * x, 14);
    a  = SIN_B - rnd_sh(SIN_C * x2, 14);
    t  = SIN_A - rnd_sh(a * x2, 14);
    p  = rnd_sh(t * x, 14);
    if (p > QUARTER) p = QUARTER;
    if (p < 0) p = 0;
    return p;
  endfunction

  function automatic longint turn_sine(longint ang);
    longint q, x, p;
    q = (ang >> 14) & 3;
    x = ang & 16'h3FFF;
    p = (q == 0 || q == 2) ? quarter_wave(x) : quarter_wave(QUARTER - x);
    return (q >= 2) ? -p : p;
  endfunction

  function automatic longint clip_count(longint c);
    if (c == 0) return 1;
    if (c > MAX_DIV) return MAX_DIV;
    return c;
  endfunction

  function automatic longint grid_fraction(longint idx, longint cnt);
    if (idx > cnt) idx = cnt;
    return (idx * 65536 + cnt / 2) / cnt;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic vertex_word_t torus_vertex(longint ri, longint si);
    vertex_word_t w;
    longint tu, tv, su, cu, sv, cv, r;
    tu = grid_fraction(ri, clip_count(rings_q));
    tv = grid_fraction(si, clip_count(sides_q));
    su = turn_sine(tu & 16'hFFFF);
    cu = turn_sine((tu + QUARTER) & 16'hFFFF);
    sv = turn_sine(tv & 16'hFFFF);
    cv = turn_sine((tv + QUARTER) & 16'hFFFF);
    r  = outer_q - rnd_sh(inner_q * cv, 14);
    w.pos_x  = 19'(clamp(-rnd_sh(r * su, 14), -131072, 131072));
    w.pos_y  = 19'(clamp(-rnd_sh(inner_q * sv, 14), -131072, 131072));
    w.pos_z  = 19'(clamp(-rnd_sh(r * cu, 14), -131072, 131072));
    w.norm_x = 16'(clamp(rnd_sh(cv * su, 14), -16384, 16384));
    w.norm_y = 16'(clamp(-sv, -16384, 16384));
    w.norm_z = 16'(clamp(rnd_sh(cv * cu, 14), -16384, 16384));
    w.tex_u  = 17'(tu);
    w.tex_v  = 17'(tv);
    return w;
  endfunction

  // receiver ready: random stall, or a long counted hold-off
  always @(posedge clk) begin
    if (rst) begin
      vertex.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      vertex.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      vertex.ready <= ($urandom_range(99) >= take_stall);
    end
  end

  // compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    vertex_word_t got, want;
    if (!rst && vertex.valid && vertex.ready) begin
      got = {vertex.pos_x, vertex.pos_y, vertex.pos_z, vertex.norm_x,
             vertex.norm_y, vertex.norm_z, vertex.tex_u, vertex.tex_v};
      if (vertex_q.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        fails++;
      end else begin
        want = vertex_q.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected %p actual %p", $time, want, got);
          fails++;
        end
      end
    end
  end

  // valid stays high after an accepted word so back-to-back words need no gap
  task automatic send_word(input logic [10:0] ri, input logic [10:0] si);
    while ($urandom_range(99) < send_idle) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid      <= 1'b1;
    item.ring_index <= ri;
    item.side_index <= si;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    vertex_q.push_back(torus_vertex(ri, si));
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 5) @(posedge clk);
  endtask

  task automatic write_reg(input trv_reg_t idx, input logic [15:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= d;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_OUTER: outer_q = d;
      REG_INNER: inner_q = d;
      REG_RINGS: rings_q = d & 11'h7FF;
      REG_SIDES: sides_q = d & 11'h7FF;
      default: ;
    endcase
  endtask

  task automatic set_shape(input logic [15:0] o, input logic [15:0] i,
                           input logic [10:0] rc, input logic [10:0] sc);
    drain();
    write_reg(REG_OUTER, o);
    write_reg(REG_INNER, i);
    write_reg(REG_RINGS, rc);
    write_reg(REG_SIDES, sc);
    cfg.valid <= 1'b0;
  endtask

  // extremes of the indices and counts
  task automatic test_directed();
    send_word(0, 0);
    send_word(32, 16);
    send_word(2047, 2047);
    send_word(8, 4);
    send_word(16, 8);
    send_word(24, 12);
    set_shape(16'hFFFF, 16'hFFFF, 0, 2047);
    send_word(0, 0);
    send_word(1, 1024);
    send_word(2047, 512);
    send_word(5, 1023);
    set_shape(0, 0, 1024, 1);
    send_word(1023, 0);
    send_word(1024, 1);
    send_word(512, 2047);
    set_shape(16'h8000, 16'h7FFF, 3, 7);
    for (int k = 0; k < 8; k++) send_word(k, k);
  endtask

  // random indices in one idling phase
  task automatic test_random(input int n, input int si, input int ts);
    send_idle  = si;
    take_stall = ts;
    for (int k = 0; k < n; k++) begin
      logic [10:0] ri, sd;
      ri = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(rings_q));
      sd = ($urandom_range(9) == 0) ? 11'($urandom) : 11'($urandom_range(sides_q));
      send_word(ri, sd);
    end
  endtask

  // long receiver hold-off while the sender keeps offering, then a full drain and a second burst
  task automatic test_back_pressure();
    send_idle = 0;
    take_stall = 0;
    hold_cycles = 200;
    for (int k = 0; k < 60; k++)
      send_word(11'($urandom_range(rings_q)), 11'($urandom_range(sides_q)));
    drain();
    for (int k = 0; k < 20; k++)
      send_word(11'($urandom_range(rings_q)), 11'($urandom_range(sides_q)));
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.index = REG_OUTER;
    cfg.data  = '0;
    item.valid = 1'b0;
    item.ring_index = '0;
    item.side_index = '0;
    outer_q = 4096;
    inner_q = 1638;
    rings_q = 32;
    sides_q = 16;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_shape(4096, 1638, 32, 16);
    test_random(220, 0, 0);
    set_shape(16'($urandom), 16'($urandom), 11'($urandom_range(1, 1024)),
              11'($urandom_range(1, 1024)));
    test_random(220, 70, 0);
    set_shape(16'hFFFF, 16'hFFFF, 1024, 1024);
    test_random(220, 0, 70);
    set_shape(16'($urandom), 16'($urandom), 11'($urandom_range(1, 64)),
              11'($urandom_range(1, 64)));
    test_random(220, 38, 38);
    test_back_pressure();
    drain();
    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

[torus_vertex_generator.f]
src/trv_pkg.sv
src/trv_if.sv
src/trv_divider.sv
src/trv_sine.sv
src/trv_shape.sv
src/torus_vertex_generator.sv
src/trv_checker.sv
bench/tb_if.sv
bench/tb_top.sv
